/* rtl/barycentric_pixel_weights_defines.svh */
// ----------------------------------------------------------------------------
// Barycentric pixel weights: assertion macros
// Shared concurrent assertion forms; the using scope supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef BARYCENTRIC_PIXEL_WEIGHTS_DEFINES_SVH
`define BARYCENTRIC_PIXEL_WEIGHTS_DEFINES_SVH

// Check that cons follows whenever ante holds.
`define BPW_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpw assertion failed");

// Check that expr never holds.
`define BPW_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bpw assertion failed");

`endif

/* rtl/bpw_pkg.sv */
// ----------------------------------------------------------------------------
// Barycentric pixel weights package
// Shared constants, register indexes and pipeline depth helpers.
// ----------------------------------------------------------------------------
package bpw_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ATTR_BITS_DEF  = 16;

    localparam int NUM_VERTS     = 3;
    localparam int NUM_EDGES     = 3;
    localparam int CFG_ADDR_BITS = 3;
    // Integer bits of a weight, sign included (Q3.FRAC).
    localparam int INT_BITS      = 4;

    localparam logic [CFG_ADDR_BITS-1:0] REG_VERTEX1_X = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_VERTEX1_Y = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_VERTEX2_X = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_VERTEX2_Y = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_VERTEX3_X = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_VERTEX3_Y = 3'd5;

    // Edge i runs from vertex EDGE_P[i] to vertex EDGE_Q[i]; its opposite vertex is i.
    localparam int EDGE_P [NUM_EDGES] = '{1, 0, 0};
    localparam int EDGE_Q [NUM_EDGES] = '{2, 2, 1};

    localparam int EDGE_STAGES   = 3;
    localparam int DIV_EXTRA     = 3;
    localparam int INTERP_STAGES = 3;

    function automatic int weight_bits(input int frac);
        return frac + INT_BITS;
    endfunction

    function automatic int lane_latency(input int frac);
        return weight_bits(frac) + DIV_EXTRA;
    endfunction

    function automatic int pipe_latency(input int frac);
        return EDGE_STAGES + lane_latency(frac) + INTERP_STAGES;
    endfunction

endpackage

/* rtl/bpw_setup.sv */
// ----------------------------------------------------------------------------
// Barycentric pixel weights: triangle setup
// Vertex registers, edge vectors and the per-edge divisors.
// ----------------------------------------------------------------------------
module bpw_setup #(
    parameter int COORD_BITS = bpw_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bpw_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [COORD_BITS-1:0]                 cfg_wdata,
    output logic signed [COORD_BITS-1:0]          piv_x     [bpw_pkg::NUM_EDGES],
    output logic signed [COORD_BITS-1:0]          piv_y     [bpw_pkg::NUM_EDGES],
    output logic signed [COORD_BITS:0]            edge_dx   [bpw_pkg::NUM_EDGES],
    output logic signed [COORD_BITS:0]            edge_dy   [bpw_pkg::NUM_EDGES],
    output logic signed [2*COORD_BITS+2:0]        divisor   [bpw_pkg::NUM_EDGES],
    output logic                                  degenerate
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int EW = 2 * COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] vx_reg [bpw_pkg::NUM_VERTS];
    logic signed [COORD_BITS-1:0] vy_reg [bpw_pkg::NUM_VERTS];
    logic signed [DW-1:0] edx_reg [bpw_pkg::NUM_EDGES];
    logic signed [DW-1:0] edy_reg [bpw_pkg::NUM_EDGES];
    logic signed [DW-1:0] odx_reg [bpw_pkg::NUM_EDGES];
    logic signed [DW-1:0] ody_reg [bpw_pkg::NUM_EDGES];
    logic signed [PW-1:0] pa_reg  [bpw_pkg::NUM_EDGES];
    logic signed [PW-1:0] pb_reg  [bpw_pkg::NUM_EDGES];
    logic signed [EW-1:0] div_reg [bpw_pkg::NUM_EDGES];
    logic signed [EW-1:0] div_next [bpw_pkg::NUM_EDGES];
    logic                 degen_reg;
    logic                 degen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < bpw_pkg::NUM_VERTS; v++)
            begin
                vx_reg[v] <= '0;
                vy_reg[v] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bpw_pkg::REG_VERTEX1_X: vx_reg[0] <= cfg_wdata;
                bpw_pkg::REG_VERTEX1_Y: vy_reg[0] <= cfg_wdata;
                bpw_pkg::REG_VERTEX2_X: vx_reg[1] <= cfg_wdata;
                bpw_pkg::REG_VERTEX2_Y: vy_reg[1] <= cfg_wdata;
                bpw_pkg::REG_VERTEX3_X: vx_reg[2] <= cfg_wdata;
                bpw_pkg::REG_VERTEX3_Y: vy_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < bpw_pkg::NUM_EDGES; i++)
    begin : g_edge
        localparam int P = bpw_pkg::EDGE_P[i];
        localparam int Q = bpw_pkg::EDGE_Q[i];

        assign piv_x[i] = vx_reg[P];
        assign piv_y[i] = vy_reg[P];

        // Edge vector, then the opposite vertex relative to the pivot.
        always_ff @(posedge clk)
        begin
            edx_reg[i] <= DW'(vx_reg[Q]) - DW'(vx_reg[P]);
            edy_reg[i] <= DW'(vy_reg[Q]) - DW'(vy_reg[P]);
            odx_reg[i] <= DW'(vx_reg[i]) - DW'(vx_reg[P]);
            ody_reg[i] <= DW'(vy_reg[i]) - DW'(vy_reg[P]);
            pa_reg[i]  <= edy_reg[i] * odx_reg[i];
            pb_reg[i]  <= edx_reg[i] * ody_reg[i];
            div_reg[i] <= div_next[i];
        end

        assign div_next[i] = EW'(pa_reg[i]) - EW'(pb_reg[i]);
        assign edge_dx[i]  = edx_reg[i];
        assign edge_dy[i]  = edy_reg[i];
        assign divisor[i]  = div_reg[i];
    end

    always_comb
    begin
        degen_next = 1'b0;
        for (int i = 0; i < bpw_pkg::NUM_EDGES; i++)
        begin
            if (div_next[i] == '0)
            begin
                degen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degen_reg <= 1'b1;
        end
        else
        begin
            degen_reg <= degen_next;
        end
    end

    assign degenerate = degen_reg;

endmodule

/* rtl/bpw_edge.sv */
// ----------------------------------------------------------------------------
// Barycentric pixel weights: edge function evaluation
// Three stages: pivot offsets, cross products, difference.
// ----------------------------------------------------------------------------
module bpw_edge #(
    parameter int COORD_BITS = bpw_pkg::COORD_BITS_DEF,
    parameter int ATTR_BITS  = bpw_pkg::ATTR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [COORD_BITS-1:0]   pixel_x,
    input  logic signed [COORD_BITS-1:0]   pixel_y,
    input  logic signed [ATTR_BITS-1:0]    attr_in   [bpw_pkg::NUM_VERTS],
    input  logic signed [COORD_BITS-1:0]   piv_x     [bpw_pkg::NUM_EDGES],
    input  logic signed [COORD_BITS-1:0]   piv_y     [bpw_pkg::NUM_EDGES],
    input  logic signed [COORD_BITS:0]     edge_dx   [bpw_pkg::NUM_EDGES],
    input  logic signed [COORD_BITS:0]     edge_dy   [bpw_pkg::NUM_EDGES],
    output logic                           out_valid,
    output logic signed [2*COORD_BITS+2:0] edge_val  [bpw_pkg::NUM_EDGES],
    output logic signed [ATTR_BITS-1:0]    attr_out  [bpw_pkg::NUM_VERTS]
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int EW = 2 * COORD_BITS + 3;
    localparam int NS = bpw_pkg::EDGE_STAGES;

    logic                 valid_reg [NS];
    logic signed [ATTR_BITS-1:0] attr_reg [NS][bpw_pkg::NUM_VERTS];
    logic signed [DW-1:0] dx_reg [bpw_pkg::NUM_EDGES];
    logic signed [DW-1:0] dy_reg [bpw_pkg::NUM_EDGES];
    logic signed [PW-1:0] pa_reg [bpw_pkg::NUM_EDGES];
    logic signed [PW-1:0] pb_reg [bpw_pkg::NUM_EDGES];
    logic signed [EW-1:0] e_reg  [bpw_pkg::NUM_EDGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        attr_reg[0] <= attr_in;
        for (int s = 1; s < NS; s++)
        begin
            attr_reg[s] <= attr_reg[s-1];
        end
        for (int i = 0; i < bpw_pkg::NUM_EDGES; i++)
        begin
            dx_reg[i] <= DW'(pixel_x) - DW'(piv_x[i]);
            dy_reg[i] <= DW'(pixel_y) - DW'(piv_y[i]);
            pa_reg[i] <= edge_dy[i] * dx_reg[i];
            pb_reg[i] <= edge_dx[i] * dy_reg[i];
            e_reg[i]  <= EW'(pa_reg[i]) - EW'(pb_reg[i]);
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign edge_val  = e_reg;
    assign attr_out  = attr_reg[NS-1];

endmodule

/* rtl/bpw_div.sv */
// ----------------------------------------------------------------------------
// Barycentric pixel weights: weight divider lane
// Pipelined restoring divide, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module bpw_div #(
    parameter int EDGE_BITS = 2 * bpw_pkg::COORD_BITS_DEF + 3,
    parameter int FRAC_BITS = bpw_pkg::FRAC_BITS_DEF
) (
    input  logic                                               clk,
    input  logic signed [EDGE_BITS-1:0]                        edge_val,
    input  logic signed [EDGE_BITS-1:0]                        divisor,
    output logic signed [bpw_pkg::weight_bits(FRAC_BITS)-1:0]  weight,
    output logic                                               unit_ok
);

    localparam int W  = bpw_pkg::weight_bits(FRAC_BITS);
    localparam int EB = EDGE_BITS;
    localparam int IB = bpw_pkg::INT_BITS;

    logic [EB-1:0] emag_reg;
    logic [EB-1:0] dmag_reg;
    logic          eneg_reg;
    logic          dneg_reg;
    logic          ezero_reg;

    logic [EB-1:0] rem_reg  [W+1];
    logic [EB-1:0] dm_reg   [W+1];
    logic [W-1:0]  quo_reg  [W+1];
    logic [IB-1:0] elo_reg  [W+1];
    logic          neg_reg  [W+1];
    logic          ovf_reg  [W+1];
    logic          unit_reg [W+1];

    logic signed [W-1:0] weight_reg;
    logic                unit_out_reg;

    // Split into sign and magnitude.
    always_ff @(posedge clk)
    begin
        eneg_reg  <= edge_val[EB-1];
        dneg_reg  <= divisor[EB-1];
        ezero_reg <= (edge_val == '0);
        emag_reg  <= edge_val[EB-1] ? EB'(-edge_val) : EB'(edge_val);
        dmag_reg  <= divisor[EB-1] ? EB'(-divisor) : EB'(divisor);
    end

    // Overflow when the quotient reaches 2^W, range test, first remainder.
    always_ff @(posedge clk)
    begin
        ovf_reg[0]  <= {{IB{1'b0}}, emag_reg} >= {dmag_reg, {IB{1'b0}}};
        unit_reg[0] <= (ezero_reg || (eneg_reg == dneg_reg)) && (emag_reg <= dmag_reg);
        neg_reg[0]  <= eneg_reg ^ dneg_reg;
        rem_reg[0]  <= emag_reg >> IB;
        dm_reg[0]   <= dmag_reg;
        elo_reg[0]  <= emag_reg[IB-1:0];
        quo_reg[0]  <= '0;
    end

    for (genvar s = 0; s < W; s++)
    begin : g_step
        localparam int K = W - 1 - s;
        logic          nb;
        logic [EB:0]   trial;
        logic [EB:0]   diff;
        logic          take;

        if (K >= FRAC_BITS)
        begin : g_num
            assign nb = elo_reg[s][K-FRAC_BITS];
        end
        else
        begin : g_zero
            assign nb = 1'b0;
        end

        assign trial = {rem_reg[s], nb};
        assign diff  = trial - {1'b0, dm_reg[s]};
        assign take  = (trial >= {1'b0, dm_reg[s]});

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= take ? diff[EB-1:0] : trial[EB-1:0];
            quo_reg[s+1]  <= {quo_reg[s][W-2:0], take};
            dm_reg[s+1]   <= dm_reg[s];
            elo_reg[s+1]  <= elo_reg[s];
            neg_reg[s+1]  <= neg_reg[s];
            ovf_reg[s+1]  <= ovf_reg[s];
            unit_reg[s+1] <= unit_reg[s];
        end
    end

    // Apply sign and clamp to the weight range.
    always_ff @(posedge clk)
    begin
        unit_out_reg <= unit_reg[W];
        if (neg_reg[W])
        begin
            if (ovf_reg[W] || (quo_reg[W] > {1'b1, {(W-1){1'b0}}}))
            begin
                weight_reg <= {1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                weight_reg <= ~quo_reg[W] + W'(1);
            end
        end
        else
        begin
            if (ovf_reg[W] || quo_reg[W][W-1])
            begin
                weight_reg <= {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                weight_reg <= quo_reg[W];
            end
        end
    end

    assign weight  = weight_reg;
    assign unit_ok = unit_out_reg;

endmodule

/* rtl/bpw_interp.sv */
// ----------------------------------------------------------------------------
// Barycentric pixel weights: attribute interpolation and result register
// Multiply, sum, then floor shift with saturation and degenerate masking.
// ----------------------------------------------------------------------------
module bpw_interp #(
    parameter int FRAC_BITS = bpw_pkg::FRAC_BITS_DEF,
    parameter int ATTR_BITS = bpw_pkg::ATTR_BITS_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               in_valid,
    input  logic signed [bpw_pkg::weight_bits(FRAC_BITS)-1:0]  weight_in [bpw_pkg::NUM_VERTS],
    input  logic                                               unit_ok   [bpw_pkg::NUM_VERTS],
    input  logic signed [ATTR_BITS-1:0]                        attr_in   [bpw_pkg::NUM_VERTS],
    input  logic                                               degenerate,
    output logic                                               done,
    output logic signed [bpw_pkg::weight_bits(FRAC_BITS)-1:0]  weight_out [bpw_pkg::NUM_VERTS],
    output logic                                               in_tri,
    output logic signed [ATTR_BITS-1:0]                        attr_interp,
    output logic                                               degenerate_out
);

    localparam int W    = bpw_pkg::weight_bits(FRAC_BITS);
    localparam int MW   = W + ATTR_BITS;
    localparam int SUMW = MW + 2;

    logic                 valid_m_reg;
    logic                 valid_s_reg;
    logic                 done_reg;
    logic signed [MW-1:0] prod_reg [bpw_pkg::NUM_VERTS];
    logic signed [W-1:0]  wm_reg   [bpw_pkg::NUM_VERTS];
    logic signed [W-1:0]  ws_reg   [bpw_pkg::NUM_VERTS];
    logic signed [W-1:0]  wo_reg   [bpw_pkg::NUM_VERTS];
    logic                 in_m_reg;
    logic                 in_s_reg;
    logic                 inside_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [SUMW-1:0] shifted;
    logic signed [ATTR_BITS-1:0] attr_sat;
    logic signed [ATTR_BITS-1:0] attr_reg;
    logic                 degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_m_reg <= 1'b0;
            valid_s_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_m_reg <= in_valid;
            valid_s_reg <= valid_m_reg;
            done_reg    <= valid_s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < bpw_pkg::NUM_VERTS; i++)
        begin
            prod_reg[i] <= weight_in[i] * attr_in[i];
        end
        wm_reg   <= weight_in;
        in_m_reg <= unit_ok[0] && unit_ok[1] && unit_ok[2];
        sum_reg  <= SUMW'(prod_reg[0]) + SUMW'(prod_reg[1]) + SUMW'(prod_reg[2]);
        ws_reg   <= wm_reg;
        in_s_reg <= in_m_reg;
    end

    // Floor shift, then clamp when the upper bits disagree with the sign.
    assign shifted = sum_reg >>> FRAC_BITS;

    always_comb
    begin
        if ((&shifted[SUMW-1:ATTR_BITS-1]) || !(|shifted[SUMW-1:ATTR_BITS-1]))
        begin
            attr_sat = shifted[ATTR_BITS-1:0];
        end
        else if (shifted[SUMW-1])
        begin
            attr_sat = {1'b1, {(ATTR_BITS-1){1'b0}}};
        end
        else
        begin
            attr_sat = {1'b0, {(ATTR_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_s_reg)
        begin
            degen_reg <= degenerate;
            if (degenerate)
            begin
                for (int i = 0; i < bpw_pkg::NUM_VERTS; i++)
                begin
                    wo_reg[i] <= '0;
                end
                inside_reg <= 1'b0;
                attr_reg   <= '0;
            end
            else
            begin
                wo_reg     <= ws_reg;
                inside_reg <= in_s_reg;
                attr_reg   <= attr_sat;
            end
        end
    end

    assign done           = done_reg;
    assign weight_out     = wo_reg;
    assign in_tri         = inside_reg;
    assign attr_interp    = attr_reg;
    assign degenerate_out = degen_reg;

endmodule

/* rtl/barycentric_pixel_weights.sv */
// ----------------------------------------------------------------------------
// Barycentric pixel weights
// Edge-function barycentric weights, inside test and attribute interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Write the six vertex coordinates through cfg_we / cfg_addr / cfg_wdata
//   (index 0..5: v1 x, v1 y, v2 x, v2 y, v3 x, v3 y); other indexes are
//   dropped. Write them only while no pixel is in flight.
//   A pixel transfer happens at each clock edge where start is high and busy
//   is low. busy stays low: the pipeline takes one pixel every cycle.
//   Each result shows on the output ports for one cycle with done high,
//   after the pixel has passed three stages of edge functions,
//   FRAC_BITS + 7 stages of divider lanes (one quotient bit per stage,
//   three lanes side by side) and three stages of interpolation.
//   The receiver cannot stall; results never wait.
//   Reset clears the vertices to zero and empties the pipeline; the vertex
//   divisors settle through the edge, product and divisor registers after any write.
//   A zero divisor marks the result degenerate with all other fields zero.
// ----------------------------------------------------------------------------
module barycentric_pixel_weights #(
    parameter int COORD_BITS = bpw_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bpw_pkg::FRAC_BITS_DEF,
    parameter int ATTR_BITS  = bpw_pkg::ATTR_BITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    output logic                                              busy,
    input  logic signed [COORD_BITS-1:0]                      pixel_x,
    input  logic signed [COORD_BITS-1:0]                      pixel_y,
    input  logic signed [ATTR_BITS-1:0]                       attr_at_v1,
    input  logic signed [ATTR_BITS-1:0]                       attr_at_v2,
    input  logic signed [ATTR_BITS-1:0]                       attr_at_v3,
    input  logic                                              cfg_we,
    input  logic [bpw_pkg::CFG_ADDR_BITS-1:0]                 cfg_addr,
    input  logic [COORD_BITS-1:0]                             cfg_wdata,
    output logic                                              done,
    output logic signed [bpw_pkg::weight_bits(FRAC_BITS)-1:0] alpha_weight,
    output logic signed [bpw_pkg::weight_bits(FRAC_BITS)-1:0] beta_weight,
    output logic signed [bpw_pkg::weight_bits(FRAC_BITS)-1:0] gamma_weight,
    output logic                                              inside_flag,
    output logic signed [ATTR_BITS-1:0]                       attr_interp,
    output logic                                              degenerate_flag
);

    localparam int W        = bpw_pkg::weight_bits(FRAC_BITS);
    localparam int EW       = 2 * COORD_BITS + 3;
    localparam int LANE_LAT = bpw_pkg::lane_latency(FRAC_BITS);

    logic signed [COORD_BITS-1:0] piv_x   [bpw_pkg::NUM_EDGES];
    logic signed [COORD_BITS-1:0] piv_y   [bpw_pkg::NUM_EDGES];
    logic signed [COORD_BITS:0]   edge_dx [bpw_pkg::NUM_EDGES];
    logic signed [COORD_BITS:0]   edge_dy [bpw_pkg::NUM_EDGES];
    logic signed [EW-1:0]         divisor [bpw_pkg::NUM_EDGES];
    logic                         degenerate;

    logic signed [ATTR_BITS-1:0]  attr_in  [bpw_pkg::NUM_VERTS];
    logic                         edge_valid;
    logic signed [EW-1:0]         edge_val [bpw_pkg::NUM_EDGES];
    logic signed [ATTR_BITS-1:0]  edge_attr [bpw_pkg::NUM_VERTS];

    logic signed [W-1:0]          weight   [bpw_pkg::NUM_VERTS];
    logic                         unit_ok  [bpw_pkg::NUM_VERTS];
    logic signed [W-1:0]          weight_o [bpw_pkg::NUM_VERTS];

    // Valid and attributes ride alongside the divider lanes.
    logic                         valid_dly_reg [LANE_LAT];
    logic signed [ATTR_BITS-1:0]  attr_dly_reg  [LANE_LAT][bpw_pkg::NUM_VERTS];

    // Every pixel is taken as it comes.
    assign busy = 1'b0;

    assign attr_in[0] = attr_at_v1;
    assign attr_in[1] = attr_at_v2;
    assign attr_in[2] = attr_at_v3;

    bpw_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .piv_x      (piv_x),
        .piv_y      (piv_y),
        .edge_dx    (edge_dx),
        .edge_dy    (edge_dy),
        .divisor    (divisor),
        .degenerate (degenerate)
    );

    bpw_edge #(
        .COORD_BITS (COORD_BITS),
        .ATTR_BITS  (ATTR_BITS)
    ) u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .attr_in   (attr_in),
        .piv_x     (piv_x),
        .piv_y     (piv_y),
        .edge_dx   (edge_dx),
        .edge_dy   (edge_dy),
        .out_valid (edge_valid),
        .edge_val  (edge_val),
        .attr_out  (edge_attr)
    );

    for (genvar i = 0; i < bpw_pkg::NUM_EDGES; i++)
    begin : g_lane
        bpw_div #(
            .EDGE_BITS (EW),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk      (clk),
            .edge_val (edge_val[i]),
            .divisor  (divisor[i]),
            .weight   (weight[i]),
            .unit_ok  (unit_ok[i])
        );
    end

    // Advance valid with reset, attributes without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LANE_LAT; s++)
            begin
                valid_dly_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_dly_reg[0] <= edge_valid;
            for (int s = 1; s < LANE_LAT; s++)
            begin
                valid_dly_reg[s] <= valid_dly_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        attr_dly_reg[0] <= edge_attr;
        for (int s = 1; s < LANE_LAT; s++)
        begin
            attr_dly_reg[s] <= attr_dly_reg[s-1];
        end
    end

    bpw_interp #(
        .FRAC_BITS (FRAC_BITS),
        .ATTR_BITS (ATTR_BITS)
    ) u_interp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (valid_dly_reg[LANE_LAT-1]),
        .weight_in      (weight),
        .unit_ok        (unit_ok),
        .attr_in        (attr_dly_reg[LANE_LAT-1]),
        .degenerate     (degenerate),
        .done           (done),
        .weight_out     (weight_o),
        .in_tri         (inside_flag),
        .attr_interp    (attr_interp),
        .degenerate_out (degenerate_flag)
    );

    assign alpha_weight = weight_o[0];
    assign beta_weight  = weight_o[1];
    assign gamma_weight = weight_o[2];

endmodule

/* rtl/bpw_checker.sv */
// ----------------------------------------------------------------------------
// Barycentric pixel weights: port checker
// Latency and result consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "barycentric_pixel_weights_defines.svh"

module bpw_checker #(
    parameter int COORD_BITS = bpw_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bpw_pkg::FRAC_BITS_DEF,
    parameter int ATTR_BITS  = bpw_pkg::ATTR_BITS_DEF
) (
    input logic                                              clk,
    input logic                                              rst_n,
    input logic                                              start,
    input logic                                              busy,
    input logic signed [COORD_BITS-1:0]                      pixel_x,
    input logic signed [COORD_BITS-1:0]                      pixel_y,
    input logic signed [ATTR_BITS-1:0]                       attr_at_v1,
    input logic signed [ATTR_BITS-1:0]                       attr_at_v2,
    input logic signed [ATTR_BITS-1:0]                       attr_at_v3,
    input logic                                              cfg_we,
    input logic [bpw_pkg::CFG_ADDR_BITS-1:0]                 cfg_addr,
    input logic [COORD_BITS-1:0]                             cfg_wdata,
    input logic                                              done,
    input logic signed [bpw_pkg::weight_bits(FRAC_BITS)-1:0] alpha_weight,
    input logic signed [bpw_pkg::weight_bits(FRAC_BITS)-1:0] beta_weight,
    input logic signed [bpw_pkg::weight_bits(FRAC_BITS)-1:0] gamma_weight,
    input logic                                              inside_flag,
    input logic signed [ATTR_BITS-1:0]                       attr_interp,
    input logic                                              degenerate_flag
);

    localparam int W       = bpw_pkg::weight_bits(FRAC_BITS);
    localparam int LATENCY = bpw_pkg::pipe_latency(FRAC_BITS);

    `BPW_ASSERT_IMPLY(a_fixed_latency, start && !busy, ##LATENCY done)
    `BPW_ASSERT_NEVER(a_no_spurious_done, done && !$past(start && !busy, LATENCY))
    `BPW_ASSERT_IMPLY(a_degenerate_zero, done && degenerate_flag, alpha_weight == '0 && beta_weight == '0 && gamma_weight == '0 && attr_interp == '0 && !inside_flag)
    `BPW_ASSERT_IMPLY(a_inside_nonneg, done && inside_flag, !alpha_weight[W-1] && !beta_weight[W-1] && !gamma_weight[W-1])

endmodule

bind barycentric_pixel_weights bpw_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ATTR_BITS  (ATTR_BITS)
) u_bpw_checker (.*);

/* test/tb_barycentric_pixel_weights.sv */
// ----------------------------------------------------------------------------
// Barycentric pixel weights testbench
// Drives pixel transfers against a range of vertex settings, predicts each
// result with an independent fixed-point model of the edge-function weights,
// and checks every strobed result field by field, in order.
// ----------------------------------------------------------------------------
module tb_barycentric_pixel_weights;

    localparam int CB = bpw_pkg::COORD_BITS_DEF;
    localparam int FB = bpw_pkg::FRAC_BITS_DEF;
    localparam int AB = bpw_pkg::ATTR_BITS_DEF;
    localparam int WB = FB + bpw_pkg::INT_BITS;
    localparam int AW = bpw_pkg::CFG_ADDR_BITS;
    // Pipeline depth plus margin; used for the quiet stretch before a write.
    localparam int PIPE_WAIT  = FB + 13 + 12;
    // Vertex divisors settle after a write through the edge, product and divisor registers, with margin.
    localparam int SETTLE     = 5;
    localparam int CYCLE_CAP  = 400000;
    localparam int RAND_ITEMS = 900;
    localparam int PHASES     = 9;

    typedef struct packed {
        logic signed [WB-1:0] alpha;
        logic signed [WB-1:0] beta;
        logic signed [WB-1:0] gamma;
        logic                 in_tri;
        logic signed [AB-1:0] attr;
        logic                 degen;
    } weights_t;

    typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [AW-1:0]        addr;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic signed [AB-1:0] a1;
        logic signed [AB-1:0] a2;
        logic signed [AB-1:0] a3;
        bit                   typed;
        weights_t             want;
    } row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [CB-1:0] pixel_x;
    logic signed [CB-1:0] pixel_y;
    logic signed [AB-1:0] attr_at_v1;
    logic signed [AB-1:0] attr_at_v2;
    logic signed [AB-1:0] attr_at_v3;
    logic cfg_we;
    logic [AW-1:0] cfg_addr;
    logic [CB-1:0] cfg_wdata;
    logic done;
    logic signed [WB-1:0] alpha_weight;
    logic signed [WB-1:0] beta_weight;
    logic signed [WB-1:0] gamma_weight;
    logic inside_flag;
    logic signed [AB-1:0] attr_interp;
    logic degenerate_flag;

    barycentric_pixel_weights u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .attr_at_v1      (attr_at_v1),
        .attr_at_v2      (attr_at_v2),
        .attr_at_v3      (attr_at_v3),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .alpha_weight    (alpha_weight),
        .beta_weight     (beta_weight),
        .gamma_weight    (gamma_weight),
        .inside_flag     (inside_flag),
        .attr_interp     (attr_interp),
        .degenerate_flag (degenerate_flag)
    );

    // Shadow copy of the vertex registers: x1 y1 x2 y2 x3 y3.
    logic signed [CB-1:0] vert_shadow [6];
    weights_t             pending_weights [$];
    row_t                 plan [$];

    int errors;
    int cycles;
    int pixels_sent;
    int results_seen;
    int inside_seen;
    int degen_seen;
    int clamp_seen;
    bit idle_enable;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint edge_at(longint px, longint py, longint qx, longint qy,
                                       longint x, longint y);
        return (qy - py) * x - (qx - px) * y + py * qx - px * qy;
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Q-format ratio e/d, truncated toward zero and clamped to the weight range.
    function automatic longint ratio_q(longint e, longint d);
        longint q;
        longint lim;
        lim = longint'(1) << (WB - 1);
        q   = (abs_of(e) << FB) / abs_of(d);
        if ((e < 0) != (d < 0))
            return (q > lim) ? -lim : -q;
        return (q > lim - 1) ? lim - 1 : q;
    endfunction

    function automatic bit within_unit(longint e, longint d);
        if (e != 0 && ((e < 0) != (d < 0)))
            return 1'b0;
        return abs_of(e) <= abs_of(d);
    endfunction

    function automatic weights_t predict_weights(longint px, longint py,
                                                 longint a1, longint a2, longint a3);
        weights_t r;
        longint x1, y1, x2, y2, x3, y3;
        longint d1, d2, d3, e1, e2, e3, w1, w2, w3, acc, amax;
        x1 = longint'(vert_shadow[0]); y1 = longint'(vert_shadow[1]);
        x2 = longint'(vert_shadow[2]); y2 = longint'(vert_shadow[3]);
        x3 = longint'(vert_shadow[4]); y3 = longint'(vert_shadow[5]);
        r  = '0;
        d1 = edge_at(x2, y2, x3, y3, x1, y1);
        d2 = edge_at(x1, y1, x3, y3, x2, y2);
        d3 = edge_at(x1, y1, x2, y2, x3, y3);
        if (d1 == 0 || d2 == 0 || d3 == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        e1 = edge_at(x2, y2, x3, y3, px, py);
        e2 = edge_at(x1, y1, x3, y3, px, py);
        e3 = edge_at(x1, y1, x2, y2, px, py);
        w1 = ratio_q(e1, d1);
        w2 = ratio_q(e2, d2);
        w3 = ratio_q(e3, d3);
        // Arithmetic shift floors, matching the block's rounding of negatives.
        acc  = (w1 * a1 + w2 * a2 + w3 * a3) >>> FB;
        amax = (longint'(1) << (AB - 1)) - 1;
        if (acc > amax)
            acc = amax;
        if (acc < -amax - 1)
            acc = -amax - 1;
        r.alpha  = w1[WB-1:0];
        r.beta   = w2[WB-1:0];
        r.gamma  = w3[WB-1:0];
        r.in_tri = within_unit(e1, d1) && within_unit(e2, d2) && within_unit(e3, d3);
        r.attr   = acc[AB-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed plan builders
    // ------------------------------------------------------------------------
    function automatic void plan_write(logic [AW-1:0] a, logic signed [CB-1:0] v);
        row_t r;
        r       = '{kind: ROW_WRITE, default: '0};
        r.addr  = a;
        r.px    = v;
        plan.push_back(r);
    endfunction

    function automatic void plan_triangle(int x1, int y1, int x2, int y2, int x3, int y3);
        plan_write(bpw_pkg::REG_VERTEX1_X, x1[CB-1:0]);
        plan_write(bpw_pkg::REG_VERTEX1_Y, y1[CB-1:0]);
        plan_write(bpw_pkg::REG_VERTEX2_X, x2[CB-1:0]);
        plan_write(bpw_pkg::REG_VERTEX2_Y, y2[CB-1:0]);
        plan_write(bpw_pkg::REG_VERTEX3_X, x3[CB-1:0]);
        plan_write(bpw_pkg::REG_VERTEX3_Y, y3[CB-1:0]);
    endfunction

    // Pass typed = 0 to take the expectation from the predictor.
    function automatic void plan_pixel(int px, int py, int a1, int a2, int a3,
                                       bit typed, weights_t want);
        row_t r;
        r       = '{kind: ROW_PIXEL, default: '0};
        r.px    = px[CB-1:0];
        r.py    = py[CB-1:0];
        r.a1    = a1[AB-1:0];
        r.a2    = a2[AB-1:0];
        r.a3    = a3[AB-1:0];
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic weights_t typed_result(int al, int be, int ga, bit ins, int at, bit dg);
        weights_t r;
        r.alpha  = al[WB-1:0];
        r.beta   = be[WB-1:0];
        r.gamma  = ga[WB-1:0];
        r.in_tri = ins;
        r.attr   = at[AB-1:0];
        r.degen  = dg;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers (all called just after a rising edge)
    // ------------------------------------------------------------------------
    task automatic quiesce();
        start <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        // Hold off a full pipeline depth so nothing is left in flight.
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    task automatic write_vertex(logic [AW-1:0] a, logic [CB-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge clk);
        if (a <= bpw_pkg::REG_VERTEX3_Y)
            vert_shadow[a] = v;
    endtask

    task automatic finish_writes();
        cfg_we <= 1'b0;
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_pixel(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                              logic signed [AB-1:0] a1, logic signed [AB-1:0] a2,
                              logic signed [AB-1:0] a3, bit typed, weights_t want);
        bit free;
        start      <= 1'b1;
        pixel_x    <= px;
        pixel_y    <= py;
        attr_at_v1 <= a1;
        attr_at_v2 <= a2;
        attr_at_v3 <= a3;
        // busy only moves on rising edges; sample it mid-cycle.
        do
        begin
            @(negedge clk);
            free = !busy;
            @(posedge clk);
        end while (!free);
        pending_weights.push_back(typed ? want
                                        : predict_weights(longint'(px), longint'(py),
                                                          longint'(a1), longint'(a2),
                                                          longint'(a3)));
        pixels_sent++;
        // Drop start for a random burst now and then.
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    function automatic int rand_coord();
        return $urandom_range(0, 4095) - 2048;
    endfunction

    function automatic int rand_attr();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    function automatic int clamp_coord(int v);
        return (v > 2047) ? 2047 : ((v < -2048) ? -2048 : v);
    endfunction

    // Pick a new triangle: mostly modest ones, sometimes tiny, huge or collinear.
    task automatic load_random_triangle(int phase);
        int v [6];
        int cx, cy, span;
        quiesce();
        cx   = rand_coord();
        cy   = rand_coord();
        span = (phase % 3 == 0) ? 4 : 300;
        foreach (v[i])
            v[i] = clamp_coord(((i % 2) ? cy : cx) + $urandom_range(0, 2 * span) - span);
        case (phase % 5)
            1:
            begin
                // Collinear: third vertex on the line through the first two.
                v[4] = clamp_coord(2 * v[2] - v[0]);
                v[5] = clamp_coord(2 * v[3] - v[1]);
                if (v[4] != 2 * v[2] - v[0] || v[5] != 2 * v[3] - v[1])
                begin
                    v[4] = v[0];
                    v[5] = v[1];
                end
            end
            3:
            begin
                v[0] = -2048; v[1] = -2048;
                v[2] = 2047;  v[3] = $urandom_range(0, 1) ? 2047 : -2048;
                v[4] = -2048; v[5] = 2047;
            end
            default: ;
        endcase
        // Toss in a dropped write to an unused index.
        write_vertex(3'(6 + $urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
        foreach (v[i])
            write_vertex(3'(i), v[i][CB-1:0]);
        finish_writes();
    endtask

    task automatic random_pixel();
        int lo_x, hi_x, lo_y, hi_y, px, py;
        lo_x = int'(vert_shadow[0]); hi_x = int'(vert_shadow[0]);
        lo_y = int'(vert_shadow[1]); hi_y = int'(vert_shadow[1]);
        for (int i = 1; i < 3; i++)
        begin
            lo_x = (vert_shadow[2*i]   < lo_x) ? int'(vert_shadow[2*i])   : lo_x;
            hi_x = (vert_shadow[2*i]   > hi_x) ? int'(vert_shadow[2*i])   : hi_x;
            lo_y = (vert_shadow[2*i+1] < lo_y) ? int'(vert_shadow[2*i+1]) : lo_y;
            hi_y = (vert_shadow[2*i+1] > hi_y) ? int'(vert_shadow[2*i+1]) : hi_y;
        end
        if ($urandom_range(0, 3) != 0)
        begin
            // Around the bounding box, so the inside test sees both answers.
            px = clamp_coord($urandom_range(0, hi_x - lo_x + 4) + lo_x - 2);
            py = clamp_coord($urandom_range(0, hi_y - lo_y + 4) + lo_y - 2);
        end
        else
        begin
            px = rand_coord();
            py = rand_coord();
        end
        send_pixel(px[CB-1:0], py[CB-1:0], AB'(rand_attr()), AB'(rand_attr()),
                   AB'(rand_attr()), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH result %0d %s: got %0d, want %0d", results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        weights_t want;
        if (rst_n && done)
        begin
            if (pending_weights.size() == 0)
            begin
                report_mismatch("unexpected result strobe", 1, 0);
            end
            else
            begin
                want = pending_weights.pop_front();
                if (alpha_weight !== want.alpha)
                    report_mismatch("alpha_weight", longint'(alpha_weight),
                                    longint'(want.alpha));
                if (beta_weight !== want.beta)
                    report_mismatch("beta_weight", longint'(beta_weight),
                                    longint'(want.beta));
                if (gamma_weight !== want.gamma)
                    report_mismatch("gamma_weight", longint'(gamma_weight),
                                    longint'(want.gamma));
                if (inside_flag !== want.in_tri)
                    report_mismatch("inside_flag", longint'(inside_flag),
                                    longint'(want.in_tri));
                if (attr_interp !== want.attr)
                    report_mismatch("attr_interp", longint'(attr_interp),
                                    longint'(want.attr));
                if (degenerate_flag !== want.degen)
                    report_mismatch("degenerate_flag", longint'(degenerate_flag),
                                    longint'(want.degen));
                inside_seen += int'(want.in_tri);
                degen_seen  += int'(want.degen);
                if (want.attr == 16'sh7fff || want.attr == 16'sh8000
                    || want.alpha == 20'sh7ffff || want.alpha == 20'sh80000)
                    clamp_seen++;
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("barycentric_pixel_weights verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        bit was_write;
        errors       = 0;
        cycles       = 0;
        pixels_sent  = 0;
        results_seen = 0;
        inside_seen  = 0;
        degen_seen   = 0;
        clamp_seen   = 0;
        idle_enable  = 1'b0;
        foreach (vert_shadow[i])
            vert_shadow[i] = '0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        pixel_x    <= '0;
        pixel_y    <= '0;
        attr_at_v1 <= '0;
        attr_at_v2 <= '0;
        attr_at_v3 <= '0;
        cfg_we     <= 1'b0;
        cfg_addr   <= '0;
        cfg_wdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset all vertices sit at the origin: every pixel is degenerate.
        plan_pixel(0, 0, 1, 2, 3, 1'b1, typed_result(0, 0, 0, 0, 0, 1));
        plan_pixel(-2048, 2047, -32768, 32767, -1, 1'b1, typed_result(0, 0, 0, 0, 0, 1));
        // Right triangle: a pixel on a vertex takes that vertex's attribute.
        plan_triangle(0, 0, 100, 0, 0, 100);
        plan_pixel(0, 0, -32768, 32767, 5, 1'b1, typed_result(65536, 0, 0, 1, -32768, 0));
        plan_pixel(100, 0, -32768, 32767, 5, 1'b1, typed_result(0, 65536, 0, 1, 32767, 0));
        plan_pixel(0, 100, 7, -7, -32768, 1'b1, typed_result(0, 0, 65536, 1, -32768, 0));
        plan_pixel(33, 33, 1000, -2000, 3000, 1'b0, '0);
        plan_pixel(50, 50, 32767, 32767, 32767, 1'b0, '0);
        plan_pixel(-1, 0, -32768, -32768, -32768, 1'b0, '0);
        plan_pixel(2047, 2047, 32767, -32768, 32767, 1'b0, '0);
        plan_pixel(-2048, -2048, -32768, 32767, -32768, 1'b0, '0);
        // Unit triangle: far pixels clamp the weights; unused indexes drop.
        plan_triangle(0, 0, 1, 0, 0, 1);
        plan_write(3'd6, 12'hfff);
        plan_write(3'd7, 12'hfff);
        plan_pixel(2047, 2047, 32767, 32767, 32767, 1'b0, '0);
        plan_pixel(-2048, 2047, -32768, 1, 32767, 1'b0, '0);
        plan_pixel(-2048, -2048, 32767, -32768, 0, 1'b0, '0);
        plan_pixel(2047, -2048, 0, 0, 0, 1'b0, '0);
        // Coordinate extremes on the vertices.
        plan_triangle(-2048, -2048, 2047, -2048, -2048, 2047);
        plan_pixel(0, 0, 12345, -23456, 345, 1'b0, '0);
        plan_pixel(2047, 2047, 32767, 32767, -32768, 1'b0, '0);
        plan_pixel(-2048, -2048, -32768, 0, 0, 1'b0, '0);
        plan_pixel(-1, -1, -1, -1, -1, 1'b0, '0);

        was_write = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (!was_write)
                    quiesce();
                write_vertex(plan[i].addr, plan[i].px);
                was_write = 1'b1;
            end
            else
            begin
                if (was_write)
                    finish_writes();
                send_pixel(plan[i].px, plan[i].py, plan[i].a1, plan[i].a2, plan[i].a3,
                           plan[i].typed, plan[i].want);
                was_write = 1'b0;
            end
        end

        // Random phases, each on a fresh triangle; the last runs without gaps.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            load_random_triangle(ph);
            idle_enable = (ph != PHASES - 1) && (ph % 4 != 2);
            repeat (RAND_ITEMS / PHASES)
                random_pixel();
        end

        start <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);

        $display("covered %0d pixel transfers, %0d results: %0d inside, %0d degenerate,",
                 pixels_sent, results_seen, inside_seen, degen_seen);
        $display("%0d clamped, across directed and %0d random vertex settings",
                 clamp_seen, PHASES);
        if (errors == 0)
            $display("barycentric_pixel_weights verification clean");
        else
            $display("barycentric_pixel_weights verification failed");
        $finish;
    end

endmodule

/* barycentric_pixel_weights.f */
+incdir+rtl
rtl/bpw_pkg.sv
rtl/bpw_setup.sv
rtl/bpw_edge.sv
rtl/bpw_div.sv
rtl/bpw_interp.sv
rtl/barycentric_pixel_weights.sv
rtl/bpw_checker.sv
test/tb_barycentric_pixel_weights.sv
